/* sv/cia_pkg.sv */
package cia_pkg;

  localparam int QBits   = 16;
  localparam int DsrBits = 32 + QBits - 1;
  localparam int Steps   = QBits;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_NEG = 3'd4;

  typedef struct packed {
    logic               vld;
    logic [2:0]         op;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
    logic signed [31:0] p_rr;
    logic signed [31:0] p_ii;
    logic signed [31:0] p_ri;
    logic signed [31:0] p_ir;
    logic signed [31:0] p_bbr;
    logic signed [31:0] p_bbi;
  } cia_prod_t;

  typedef struct packed {
    logic               vld;
    logic               is_div;
    logic               dz;
    logic signed [32:0] re;
    logic signed [32:0] im;
    logic               neg_re;
    logic               neg_im;
    logic [31:0]        rem_re;
    logic [31:0]        rem_im;
    logic [DsrBits-1:0] dsr;
    logic [QBits-1:0]   q_re;
    logic [QBits-1:0]   q_im;
  } cia_item_t;

endpackage

/* sv/cia_mul.sv */
module cia_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [2:0]         op,
  input  logic signed [15:0] a_re,
  input  logic signed [15:0] a_im,
  input  logic signed [15:0] b_re,
  input  logic signed [15:0] b_im,
  output cia_pkg::cia_prod_t prod
);

  cia_pkg::cia_prod_t prod_r;
  cia_pkg::cia_prod_t prod_nxt;

  always_comb begin
    prod_nxt.vld   = in_vld;
    prod_nxt.op    = op;
    prod_nxt.a_re  = a_re;
    prod_nxt.a_im  = a_im;
    prod_nxt.b_re  = b_re;
    prod_nxt.b_im  = b_im;
    prod_nxt.p_rr  = 32'(a_re) * 32'(b_re);
    prod_nxt.p_ii  = 32'(a_im) * 32'(b_im);
    prod_nxt.p_ri  = 32'(a_re) * 32'(b_im);
    prod_nxt.p_ir  = 32'(a_im) * 32'(b_re);
    prod_nxt.p_bbr = 32'(b_re) * 32'(b_re);
    prod_nxt.p_bbi = 32'(b_im) * 32'(b_im);
  end

  // payload fields need no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r.vld <= 1'b0;
    end else if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

/* sv/cia_comb.sv */
module cia_comb (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  cia_pkg::cia_prod_t prod,
  output cia_pkg::cia_item_t item
);

  cia_pkg::cia_item_t item_r;
  cia_pkg::cia_item_t item_nxt;
  logic signed [32:0] nr;
  logic signed [32:0] ni;
  logic [31:0]        norm;

  always_comb begin
    nr   = 33'(prod.p_rr) + 33'(prod.p_ii);
    ni   = 33'(prod.p_ir) - 33'(prod.p_ri);
    norm = 32'(unsigned'(prod.p_bbr)) + 32'(unsigned'(prod.p_bbi));

    item_nxt.vld    = prod.vld;
    item_nxt.is_div = 1'b0;
    item_nxt.dz     = 1'b0;
    item_nxt.re     = '0;
    item_nxt.im     = '0;
    item_nxt.neg_re = nr[32];
    item_nxt.neg_im = ni[32];
    item_nxt.rem_re = nr[32] ? 32'(-nr) : nr[31:0];
    item_nxt.rem_im = ni[32] ? 32'(-ni) : ni[31:0];
    item_nxt.dsr    = {norm, (cia_pkg::QBits-1)'(0)};
    item_nxt.q_re   = '0;
    item_nxt.q_im   = '0;

    case (prod.op)
      cia_pkg::OP_ADD: begin
        item_nxt.re = 33'(prod.a_re) + 33'(prod.b_re);
        item_nxt.im = 33'(prod.a_im) + 33'(prod.b_im);
      end
      cia_pkg::OP_SUB: begin
        item_nxt.re = 33'(prod.a_re) - 33'(prod.b_re);
        item_nxt.im = 33'(prod.a_im) - 33'(prod.b_im);
      end
      cia_pkg::OP_MUL: begin
        item_nxt.re = 33'(prod.p_rr) - 33'(prod.p_ii);
        item_nxt.im = 33'(prod.p_ri) + 33'(prod.p_ir);
      end
      cia_pkg::OP_DIV: begin
        if (norm == '0) begin
          item_nxt.dz = 1'b1;
        end else begin
          item_nxt.is_div = 1'b1;
        end
      end
      cia_pkg::OP_NEG: begin
        item_nxt.re = -33'(prod.a_re);
        item_nxt.im = -33'(prod.a_im);
      end
      default: begin
        item_nxt.re = '0;
      end
    endcase
  end

  // payload fields need no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (en) begin
      item_r <= item_nxt;
    end
  end

  assign item = item_r;

endmodule

/* sv/cia_div_step.sv */
module cia_div_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  cia_pkg::cia_item_t din,
  output cia_pkg::cia_item_t dout
);

  cia_pkg::cia_item_t dout_r;
  cia_pkg::cia_item_t dout_nxt;
  logic               ge_re;
  logic               ge_im;

  // one restoring step on each part; the divisor shifts right a bit a step
  always_comb begin
    ge_re = cia_pkg::DsrBits'(din.rem_re) >= din.dsr;
    ge_im = cia_pkg::DsrBits'(din.rem_im) >= din.dsr;
    dout_nxt        = din;
    dout_nxt.rem_re = ge_re ? din.rem_re - din.dsr[31:0] : din.rem_re;
    dout_nxt.rem_im = ge_im ? din.rem_im - din.dsr[31:0] : din.rem_im;
    dout_nxt.q_re   = {din.q_re[cia_pkg::QBits-2:0], ge_re};
    dout_nxt.q_im   = {din.q_im[cia_pkg::QBits-2:0], ge_im};
    dout_nxt.dsr    = din.dsr >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.vld <= 1'b0;
    end else if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

/* sv/complex_integer_alu.sv */
// Complex integer ALU: add, subtract, multiply, divide or negate complex
// operands with signed 16-bit parts, giving 33-bit parts that never overflow.
// Divide truncates each part toward zero; a zero divisor flags div_zero and
// gives zero parts. The block takes one transfer per cycle and each item
// passes 19 register stages: a multiplier stage, a combine stage, 16 restoring
// divider steps (one quotient bit per step) and the output register. The whole pipe
// advances together, so a held output stalls the input side.
module complex_integer_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // a_re[15:0], a_im[31:16], b_re[47:32], b_im[63:48]
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // res_re[32:0], res_im[65:33], zero fill[71:66]
  output logic        out_tuser   // div_zero
);

  logic               en;
  cia_pkg::cia_prod_t prod;
  cia_pkg::cia_item_t chain [cia_pkg::Steps+1];
  logic               out_valid_r;
  logic signed [32:0] res_re_r;
  logic signed [32:0] res_im_r;
  logic               dz_r;
  logic signed [32:0] res_re_nxt;
  logic signed [32:0] res_im_nxt;
  logic signed [32:0] q_re_ext;
  logic signed [32:0] q_im_ext;

  // advance everything whenever the output slot is free or draining
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  cia_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_vld(in_tvalid),
    .op    (in_tuser),
    .a_re  (in_tdata[15:0]),
    .a_im  (in_tdata[31:16]),
    .b_re  (in_tdata[47:32]),
    .b_im  (in_tdata[63:48]),
    .prod  (prod)
  );

  cia_comb u_comb (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (en),
    .prod (prod),
    .item (chain[0])
  );

  for (genvar k = 0; k < cia_pkg::Steps; k++) begin : g_div
    cia_div_step u_step (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .din  (chain[k]),
      .dout (chain[k+1])
    );
  end

  // apply the quotient signs for divide, pass other results through
  always_comb begin
    q_re_ext = 33'({1'b0, chain[cia_pkg::Steps].q_re});
    q_im_ext = 33'({1'b0, chain[cia_pkg::Steps].q_im});
    if (chain[cia_pkg::Steps].is_div) begin
      res_re_nxt = chain[cia_pkg::Steps].neg_re ? -q_re_ext : q_re_ext;
      res_im_nxt = chain[cia_pkg::Steps].neg_im ? -q_im_ext : q_im_ext;
    end else begin
      res_re_nxt = chain[cia_pkg::Steps].re;
      res_im_nxt = chain[cia_pkg::Steps].im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[cia_pkg::Steps].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      dz_r     <= chain[cia_pkg::Steps].dz;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, res_im_r, res_re_r};
  assign out_tuser  = dz_r;

endmodule

/* sv/cia_checker.sv */
module cia_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[65:0] == 66'd0)
    else $error("zero divisor with nonzero parts");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind complex_integer_alu cia_checker u_cia_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
